/* hw/rtl/ss_pkg.sv */
`default_nettype none
package ss_pkg;

  // store depth and derived widths
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic signed [31:0] sort_value;
    logic               is_last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_set;
    logic               overflowed;
  } out_req_t;

  // controller -> datapath
  typedef struct packed {
    logic store;      // accept one input element
    logic rd_pos;     // read store at current position
    logic take_pos;   // seed minimum with value at position
    logic rd_scan;    // read store at scan index
    logic compare;    // compare read data against running minimum
    logic emit;       // push minimum out, swap position value into its slot
  } ss_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pos_last;   // position is the final element of the set
    logic scan_last;  // scan index is the final element of the set
    logic out_free;   // output register can take a new request
  } ss_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/selection_sorter.sv */
`default_nettype none
// Selection sorter. Signed 32-bit values are loaded one request per cycle
// into a DEPTH-entry store (16 by default); the request with is_last set
// closes the set. Requests beyond DEPTH are dropped, a closing one included,
// and every result of that set then carries overflowed. After the close the
// input stalls while the set is sorted in ascending order and streamed out:
// for each position the store is walked from that position on through its
// single registered read port, each entry read and then compared; the
// smallest value is sent out and the position's old value is written into
// the slot the smallest value came from. Output stall simply holds the
// walk. Ties keep the first value found. end_of_set marks the last result.
// Loading of the next set starts in the cycle after the last result enters
// the output register.
module selection_sorter (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire ss_pkg::in_req_t in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ss_pkg::out_req_t     out_data
);
  import ss_pkg::*;

  ss_cmd_t cmd;
  ss_sts_t sts;

  // sequencing: load, seed, scan, emit
  ss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_data.is_last),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  // store, running minimum, counters and output register
  ss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* hw/rtl/ss_dp.sv */
`default_nettype none
module ss_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ss_pkg::ss_cmd_t cmd,
  output ss_pkg::ss_sts_t      sts,
  input  wire ss_pkg::in_req_t in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ss_pkg::out_req_t     out_data
);
  import ss_pkg::*;

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata_r;
  logic [IDX_W-1:0]  raddr;
  logic              wen;
  logic [IDX_W-1:0]  waddr;
  logic [31:0]       wdata;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              drop_r, drop_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic signed [31:0] best_val_r, best_val_nxt;
  logic [31:0]       pos_val_r, pos_val_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_req_t          out_data_r, out_data_nxt;

  logic              has_room;
  logic              smaller;
  logic [CNT_W-1:0]  pos_p1;
  logic [CNT_W-1:0]  scan_p1;

  assign has_room = count_r < CNT_W'(DEPTH);
  assign smaller  = $signed(rdata_r) < best_val_r;
  assign pos_p1   = CNT_W'(pos_r) + CNT_W'(1);
  assign scan_p1  = CNT_W'(scan_r) + CNT_W'(1);

  assign sts.pos_last  = pos_p1 == count_r;
  assign sts.scan_last = scan_p1 == count_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // store write port: loading or swap-back
  always_comb begin
    wen   = 1'b0;
    waddr = best_idx_r;
    wdata = pos_val_r;
    if (cmd.store && has_room) begin
      wen   = 1'b1;
      waddr = count_r[IDX_W-1:0];
      wdata = in_data.sort_value;
    end else if (cmd.emit) begin
      wen = 1'b1;
    end
  end

  assign raddr = cmd.rd_scan ? scan_r : pos_r;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_pos || cmd.rd_scan) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    pos_nxt       = pos_r;
    scan_nxt      = scan_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    pos_val_nxt   = pos_val_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.store) begin
      if (has_room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end

    if (cmd.take_pos) begin
      best_val_nxt = $signed(rdata_r);
      pos_val_nxt  = rdata_r;
      best_idx_nxt = pos_r;
      scan_nxt     = pos_p1[IDX_W-1:0];
    end

    if (cmd.compare) begin
      if (smaller) begin
        best_val_nxt = $signed(rdata_r);
        best_idx_nxt = scan_r;
      end
      scan_nxt = scan_p1[IDX_W-1:0];
    end

    if (cmd.emit) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.sorted_value = best_val_r;
      out_data_nxt.end_of_set   = sts.pos_last;
      out_data_nxt.overflowed   = drop_r;
      if (sts.pos_last) begin
        count_nxt = '0;
        drop_nxt  = 1'b0;
        pos_nxt   = '0;
      end else begin
        pos_nxt = pos_p1[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      drop_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    pos_val_r  <= pos_val_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

/* hw/rtl/ss_ctrl.sv */
`default_nettype none
module ss_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_is_last,
  output logic                 in_stall,
  output ss_pkg::ss_cmd_t      cmd,
  input  wire ss_pkg::ss_sts_t sts
);
  import ss_pkg::*;

  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_PRIME   = 3'd1;
  localparam logic [2:0] ST_FETCH   = 3'd2;
  localparam logic [2:0] ST_ISSUE   = 3'd3;
  localparam logic [2:0] ST_COMPARE = 3'd4;
  localparam logic [2:0] ST_EMIT    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_stall = state_r != ST_LOAD;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          cmd.store = 1'b1;
          if (in_is_last) begin
            state_nxt = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.take_pos = 1'b1;
        state_nxt    = sts.pos_last ? ST_EMIT : ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = ST_COMPARE;
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_nxt   = sts.scan_last ? ST_EMIT : ST_ISSUE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.pos_last ? ST_LOAD : ST_PRIME;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire
